// ===== rtl/pdlz_pkg.sv =====
// Shared types and constants for the PalmDOC LZ77 decompressor.
package pdlz_pkg;

    // History memory geometry
    localparam int HIST_DEPTH = 2048;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int CNT_W      = HIST_AW + 1;

    // Back-reference layout: 14-bit word = distance, length code
    localparam int LEN_BITS   = 3;
    localparam int WORD_W     = 14;
    localparam int DIST_W     = WORD_W - LEN_BITS;
    localparam int LRAW_W     = LEN_BITS + 2;
    localparam int LEN_MIN    = 3;
    localparam int MAX_RES    = 10;
    localparam int LEN_W      = $clog2(MAX_RES + 1);
    localparam int HI_W       = WORD_W - 8;
    localparam int LIT_W      = 4;

    // Token byte codes
    localparam logic [7:0] LIT_MIN    = 8'h01;
    localparam logic [7:0] LIT_MAX    = 8'h08;
    localparam logic [7:0] BREF_MIN   = 8'h80;
    localparam logic [7:0] PAIR_MIN   = 8'hC0;
    localparam logic [7:0] PAIR_FLIP  = 8'h80;
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ESC,
        ST_COPY
    } t_state;

    // One result byte handed to the output register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       run_last;
        logic       record_end;
        logic       bad;
    } t_emit;

    // History memory access for one cycle
    typedef struct packed {
        logic               we;
        logic [HIST_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [HIST_AW-1:0] raddr;
    } t_ram_req;

endpackage

// ===== rtl/pdlz_if.sv =====
// Valid/ready channel interfaces for compressed input and decompressed output.
interface pdlz_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pdlz_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       record_end;
    logic       bad_distance;

    modport source (output valid, output out_byte, output run_last, output record_end,
                    output bad_distance, input ready);
    modport sink   (input valid, input out_byte, input run_last, input record_end,
                    input bad_distance, output ready);
endinterface

// ===== rtl/pdlz_hist_ram.sv =====
// Single-port-write, single-port-read history RAM with write-first bypass.
module pdlz_hist_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; forward a same-cycle write to the same entry
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/pdlz_ctrl.sv =====
// Token decoder and copy sequencer driving the history memory.
module pdlz_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [7:0]        i_in_byte,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  logic              i_ld_ok,
    output pdlz_pkg::t_emit   o_emit,
    output pdlz_pkg::t_ram_req o_ram,
    input  logic [7:0]        i_rdata
);
    import pdlz_pkg::*;

    t_state             r_state, n_state;
    logic [HIST_AW-1:0] r_wp, n_wp;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [LIT_W-1:0]   r_lit, n_lit;
    logic [HI_W-1:0]    r_pend_hi, n_pend_hi;
    logic               r_pend_v, n_pend_v;
    logic               r_last, n_last;
    logic               r_bad, n_bad;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_rd_cnt, n_rd_cnt;
    logic [LEN_W-1:0]   r_wr_cnt, n_wr_cnt;
    logic [HIST_AW-1:0] r_rd_addr, n_rd_addr;
    logic               r_rd_v, n_rd_v;
    logic [7:0]         r_esc, n_esc;

    logic               w_acc;
    logic               w_clr;
    logic               w_issue;
    logic               w_final;
    logic [WORD_W-1:0]  w_word;
    logic [DIST_W-1:0]  w_dist;
    logic [LRAW_W-1:0]  w_len_raw;
    t_emit              w_emit;
    t_ram_req           w_ram;

    // Decode fields of a back-reference word
    assign w_word    = {r_pend_hi, i_in_byte};
    assign w_dist    = w_word[WORD_W-1:LEN_BITS];
    assign w_len_raw = LRAW_W'(w_word[LEN_BITS-1:0]) + LRAW_W'(LEN_MIN);
    assign w_acc     = i_in_valid && o_in_ready;
    assign w_final   = (r_wr_cnt == r_len - LEN_W'(1));

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wp      <= '0;
            r_cnt     <= '0;
            r_lit     <= '0;
            r_pend_hi <= '0;
            r_pend_v  <= 1'b0;
            r_last    <= 1'b0;
            r_bad     <= 1'b0;
            r_len     <= '0;
            r_rd_cnt  <= '0;
            r_wr_cnt  <= '0;
            r_rd_addr <= '0;
            r_rd_v    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_cnt     <= n_cnt;
            r_lit     <= n_lit;
            r_pend_hi <= n_pend_hi;
            r_pend_v  <= n_pend_v;
            r_last    <= n_last;
            r_bad     <= n_bad;
            r_len     <= n_len;
            r_rd_cnt  <= n_rd_cnt;
            r_wr_cnt  <= n_wr_cnt;
            r_rd_addr <= n_rd_addr;
            r_rd_v    <= n_rd_v;
        end
    end

    // Second byte of a space pair
    always_ff @(posedge i_clk) begin
        r_esc <= n_esc;
    end

    // Next state, result generation and memory access
    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_cnt     = r_cnt;
        n_lit     = r_lit;
        n_pend_hi = r_pend_hi;
        n_pend_v  = r_pend_v;
        n_last    = r_last;
        n_bad     = r_bad;
        n_len     = r_len;
        n_rd_cnt  = r_rd_cnt;
        n_wr_cnt  = r_wr_cnt;
        n_rd_addr = r_rd_addr;
        n_rd_v    = r_rd_v;
        n_esc     = r_esc;
        o_in_ready = 1'b0;
        w_clr     = 1'b0;
        w_issue   = 1'b0;
        w_emit    = '0;
        w_ram     = '0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_ld_ok;
                if (w_acc) begin
                    if (r_pend_v) begin
                        // Start a back-reference copy
                        n_pend_v  = 1'b0;
                        n_pend_hi = '0;
                        n_state   = ST_COPY;
                        n_last    = i_in_last;
                        n_bad     = (w_dist == '0) || (CNT_W'(w_dist) > r_cnt);
                        n_len     = (w_len_raw > LRAW_W'(MAX_RES)) ? LEN_W'(MAX_RES)
                                                                  : LEN_W'(w_len_raw);
                        n_rd_cnt  = '0;
                        n_wr_cnt  = '0;
                        n_rd_v    = 1'b0;
                        n_rd_addr = r_wp - HIST_AW'(w_dist);
                    end else if (r_lit != '0) begin
                        n_lit                 = r_lit - LIT_W'(1);
                        w_emit.valid      = 1'b1;
                        w_emit.data       = i_in_byte;
                        w_emit.run_last   = 1'b1;
                        w_emit.record_end = i_in_last;
                        w_clr             = i_in_last;
                    end else if (i_in_byte inside {[LIT_MIN:LIT_MAX]}) begin
                        n_lit = LIT_W'(i_in_byte);
                        w_clr = i_in_last;
                    end else if (i_in_byte >= PAIR_MIN) begin
                        w_emit.valid = 1'b1;
                        w_emit.data  = SPACE_BYTE;
                        n_esc        = i_in_byte ^ PAIR_FLIP;
                        n_last       = i_in_last;
                        n_state      = ST_ESC;
                    end else if (i_in_byte >= BREF_MIN) begin
                        n_pend_hi = i_in_byte[HI_W-1:0];
                        n_pend_v  = 1'b1;
                        w_clr     = i_in_last;
                    end else begin
                        w_emit.valid      = 1'b1;
                        w_emit.data       = i_in_byte;
                        w_emit.run_last   = 1'b1;
                        w_emit.record_end = i_in_last;
                        w_clr             = i_in_last;
                    end
                end
            end
            ST_ESC: begin
                if (i_ld_ok) begin
                    w_emit.valid      = 1'b1;
                    w_emit.data       = r_esc;
                    w_emit.run_last   = 1'b1;
                    w_emit.record_end = r_last;
                    w_clr             = r_last;
                    n_state           = ST_IDLE;
                end
            end
            ST_COPY: begin
                // Emit the byte whose read data has returned
                if (r_rd_v && i_ld_ok) begin
                    w_emit.valid      = 1'b1;
                    w_emit.data       = r_bad ? 8'h00 : i_rdata;
                    w_emit.run_last   = w_final;
                    w_emit.record_end = w_final && r_last;
                    w_emit.bad        = r_bad;
                    n_wr_cnt          = r_wr_cnt + LEN_W'(1);
                    if (w_final) begin
                        n_state = ST_IDLE;
                        w_clr   = r_last;
                    end
                end
                // Issue the next read once the previous one is drained
                w_issue = (r_rd_cnt != r_len) && (!r_rd_v || w_emit.valid);
                if (w_issue) begin
                    w_ram.re  = 1'b1;
                    w_ram.raddr = r_rd_addr;
                    n_rd_addr = r_rd_addr + HIST_AW'(1);
                    n_rd_cnt  = r_rd_cnt + LEN_W'(1);
                    n_rd_v    = 1'b1;
                end else if (w_emit.valid) begin
                    n_rd_v = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Record every emitted byte in the history
        if (w_emit.valid) begin
            w_ram.we    = 1'b1;
            w_ram.waddr = r_wp;
            w_ram.wdata = w_emit.data;
            n_wp        = r_wp + HIST_AW'(1);
            if (r_cnt != CNT_W'(HIST_DEPTH)) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end

        // Drop record state at the end of a record
        if (w_clr) begin
            n_wp      = '0;
            n_cnt     = '0;
            n_lit     = '0;
            n_pend_hi = '0;
            n_pend_v  = 1'b0;
        end
    end

    assign o_emit = w_emit;
    assign o_ram  = w_ram;
endmodule

// ===== rtl/palmdoc_lz77_decompressor.sv =====
// PalmDOC LZ77 decompressor top level: decoder, history RAM and output register.
// A literal, pass-through or space byte is in the output register the cycle after its
// transfer; the first copied byte of a back-reference is read from the history RAM in the
// copy state and then loaded into the output register. Input is held off while a space
// pair or a back-reference copy (length 3 to 10) finishes and while the output is stalled.
// Reset: synchronous active-low; clears pointers, counters and output valid.
module palmdoc_lz77_decompressor (
    input  logic i_clk,
    input  logic i_rst_n,
    pdlz_in_if.sink    i_in,
    pdlz_out_if.source o_out
);
    import pdlz_pkg::*;

    t_emit      w_emit;
    t_ram_req   w_ram;
    logic [7:0] w_rdata;
    logic       w_ld_ok;
    logic       r_ov;
    logic [7:0] r_obyte;
    logic       r_orun;
    logic       r_oend;
    logic       r_obad;

    assign w_ld_ok = !r_ov || o_out.ready;

    pdlz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_byte  (i_in.in_byte),
        .i_in_last  (i_in.in_last),
        .o_in_ready (i_in.ready),
        .i_ld_ok    (w_ld_ok),
        .o_emit     (w_emit),
        .o_ram      (w_ram),
        .i_rdata    (w_rdata)
    );

    pdlz_hist_ram #(
        .DEPTH (HIST_DEPTH),
        .WIDTH (8)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_ld_ok) begin
            r_ov <= w_emit.valid;
        end
    end

    // Output payload: load on a new result, hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_ld_ok && w_emit.valid) begin
            r_obyte <= w_emit.data;
            r_orun  <= w_emit.run_last;
            r_oend  <= w_emit.record_end;
            r_obad  <= w_emit.bad;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.out_byte     = r_obyte;
    assign o_out.run_last     = r_orun;
    assign o_out.record_end   = r_oend;
    assign o_out.bad_distance = r_obad;
endmodule

// ===== rtl/pdlz_checker.sv =====
// Port-level assertions for the decompressor, bound to the top level.
module pdlz_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_run_last,
    input logic       i_out_record_end,
    input logic       i_out_bad
);
    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_record_end))
        else $error("stalled output changed");

    // Record end only on the last byte of a transfer group
    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_record_end |-> i_out_run_last)
        else $error("record_end without run_last");

    // Bad distance bytes are zero
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_bad |-> i_out_byte == 8'h00)
        else $error("bad distance byte not zero");

    // No input transfer while the output is stalled
    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input ready while output stalled");

    // Output empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");
endmodule

bind palmdoc_lz77_decompressor pdlz_checker u_pdlz_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_byte       (o_out.out_byte),
    .i_out_run_last   (o_out.run_last),
    .i_out_record_end (o_out.record_end),
    .i_out_bad        (o_out.bad_distance)
);

// ===== tb/sv/palmdoc_lz77_decompressor_chk.sv =====
// Output checker for the PalmDOC LZ77 decompressor: predicts and compares every transfer.
module palmdoc_lz77_decompressor_chk (
    input  logic i_clk,
    input  logic i_rst_n,
    pdlz_in_if   i_in,
    pdlz_out_if  i_out,
    output int   o_fail_count,
    output int   o_owed_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import pdlz_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       record_end;
        logic       bad;
    } t_plain_byte;

    // Decoder state mirrored from the block
    logic [7:0]         hist_mem [HIST_DEPTH];
    logic [HIST_AW-1:0] wr_ptr;
    logic [CNT_W-1:0]   wr_count;
    logic [LIT_W-1:0]   lit_left;
    logic [HI_W-1:0]    ref_high;
    logic               ref_pending;

    t_plain_byte owed_q [$];
    int          step_count;
    int          fails;

    // Append one decompressed byte and write it into the history
    task automatic record_byte(input logic [7:0] b, input logic bad);
        owed_q.push_back('{data: b, run_last: 1'b0, record_end: 1'b0, bad: bad});
        hist_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        if (wr_count < CNT_W'(HIST_DEPTH))
            wr_count = wr_count + 1'b1;
        step_count++;
    endtask

    // Decode one compressed byte into the bytes it must produce
    task automatic decode_byte(input logic [7:0] c, input logic last);
        logic [WORD_W-1:0]  word;
        logic [DIST_W-1:0]  ref_dist;
        int unsigned        len;
        logic               bad;
        logic [7:0]         b;
        t_plain_byte        tail;
        step_count = 0;
        if (ref_pending) begin
            word     = {ref_high, c};
            ref_dist = word[WORD_W-1:LEN_BITS];
            len      = int'(word[LEN_BITS-1:0]) + LEN_MIN;
            if (len > MAX_RES)
                len = MAX_RES;
            bad = (ref_dist == '0) || (CNT_W'(ref_dist) > wr_count);
            ref_pending = 1'b0;
            ref_high    = '0;
            // copy one byte at a time so an overlapping copy repeats bytes
            for (int k = 0; k < len; k++) begin
                b = bad ? 8'h00 : hist_mem[wr_ptr - HIST_AW'(ref_dist)];
                record_byte(b, bad);
            end
        end else if (lit_left != '0) begin
            lit_left = lit_left - 1'b1;
            record_byte(c, 1'b0);
        end else if (c >= LIT_MIN && c <= LIT_MAX) begin
            lit_left = LIT_W'(c);
        end else if (c >= PAIR_MIN) begin
            record_byte(SPACE_BYTE, 1'b0);
            record_byte(c ^ PAIR_FLIP, 1'b0);
        end else if (c >= BREF_MIN) begin
            ref_high    = c[HI_W-1:0];
            ref_pending = 1'b1;
        end else begin
            record_byte(c, 1'b0);
        end

        // mark the final byte of this step
        if (step_count > 0) begin
            tail = owed_q.pop_back();
            tail.run_last   = 1'b1;
            tail.record_end = last;
            owed_q.push_back(tail);
        end

        // a record end clears everything but the history
        if (last) begin
            wr_ptr      = '0;
            wr_count    = '0;
            lit_left    = '0;
            ref_high    = '0;
            ref_pending = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %02h, got %02h", $time, name, want, got);
            fails++;
        end
    endtask

    // Compare output transfers, then predict from input transfers
    always @(posedge i_clk) begin
        t_plain_byte want;
        if (!i_rst_n) begin
            wr_ptr      = '0;
            wr_count    = '0;
            lit_left    = '0;
            ref_high    = '0;
            ref_pending = 1'b0;
            fails       = 0;
            owed_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (owed_q.size() == 0) begin
                    $display("%0t: unexpected output byte: expected none, got %02h",
                             $time, i_out.out_byte);
                    fails++;
                end else begin
                    want = owed_q.pop_front();
                    check_field("out_byte", want.data, i_out.out_byte);
                    check_field("run_last", 8'(want.run_last), 8'(i_out.run_last));
                    check_field("record_end", 8'(want.record_end), 8'(i_out.record_end));
                    check_field("bad_distance", 8'(want.bad), 8'(i_out.bad_distance));
                end
            end
            if (i_in.valid && i_in.ready)
                decode_byte(i_in.in_byte, i_in.in_last);
        end
        o_owed_count <= owed_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/sv/palmdoc_lz77_decompressor_tb.sv =====
// Testbench top for the PalmDOC LZ77 decompressor: clock, reset, stimulus and verdict.
module palmdoc_lz77_decompressor_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pdlz_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 2;
    localparam int RANDOM_ITEMS = 160;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 800000;

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;
    int   items_sent;
    int   ready_hold;
    int   cycle_count;
    int   fail_total;
    int   owed_results;

    pdlz_in_if  in_ch ();
    pdlz_out_if out_ch ();

    palmdoc_lz77_decompressor dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    palmdoc_lz77_decompressor_chk chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_total),
        .o_owed_count (owed_results)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Idle length: mostly none or short, now and then long; none in calm stretches
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Stall the output side at random
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            ready_hold   <= 0;
        end else if (ready_hold > 0) begin
            out_ch.ready <= 1'b0;
            ready_hold   <= ready_hold - 1;
        end else begin
            out_ch.ready <= 1'b1;
            ready_hold   <= pick_gap();
        end
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("palmdoc_lz77_decompressor_tb NOT OK");
            $finish;
        end
    end

    // Offer one compressed byte and hold it until the transfer
    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= c;
        in_ch.in_last <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_backref(input logic [DIST_W-1:0] ref_dist,
                                input logic [LEN_BITS-1:0] len_code, input logic last);
        logic [WORD_W-1:0] word;
        word = {ref_dist, len_code};
        send_byte(BREF_MIN | 8'(word[WORD_W-1:8]), 1'b0);
        send_byte(word[7:0], last);
    endtask

    // Hold the input until every predicted byte has come out
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (owed_results != 0);
    endtask

    // One record of random tokens, mostly well formed
    task automatic send_record(input int tokens);
        int                  produced;
        int                  kind;
        int                  run;
        int                  span;
        int                  ref_dist;
        logic [LEN_BITS-1:0] len_code;
        logic                last;
        produced = 0;
        last     = 1'b0;
        for (int t = 0; t < tokens; t++) begin
            last = (t == tokens - 1) && ($urandom_range(0, 5) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                if ($urandom_range(0, 7) == 0)
                    send_byte(8'h00, last);
                else
                    send_byte(8'($urandom_range(LIT_MAX + 1, BREF_MIN - 1)), last);
                produced += 1;
            end else if (kind < 38) begin
                run = $urandom_range(LIT_MIN, LIT_MAX);
                send_byte(8'(run), 1'b0);
                for (int k = 0; k < run; k++)
                    send_byte(8'($urandom_range(0, 255)), last && (k == run - 1));
                produced += run;
            end else if (kind < 52) begin
                send_byte(8'($urandom_range(PAIR_MIN, 255)), last);
                produced += 2;
            end else if (kind < 94) begin
                len_code = LEN_BITS'($urandom_range(0, (1 << LEN_BITS) - 1));
                if (produced > 0 && $urandom_range(0, 9) != 0) begin
                    span = (produced < HIST_DEPTH - 1) ? produced : HIST_DEPTH - 1;
                    if ($urandom_range(0, 1) == 0)
                        ref_dist = $urandom_range(1, (span < 8) ? span : 8);
                    else
                        ref_dist = $urandom_range(1, span);
                end else begin
                    ref_dist = $urandom_range(0, HIST_DEPTH - 1);
                end
                send_backref(DIST_W'(ref_dist), len_code, last);
                produced += int'(len_code) + LEN_MIN;
            end else begin
                send_byte(8'($urandom_range(0, 255)), last);
                produced += 1;
            end
        end
        // close the record on an unfinished literal run or back-reference
        if (!last) begin
            if ($urandom_range(0, 1) == 0)
                send_byte(8'($urandom_range(LIT_MIN, LIT_MAX)), 1'b1);
            else
                send_byte(8'($urandom_range(BREF_MIN, PAIR_MIN - 1)), 1'b1);
        end
    endtask

    // Long record that wraps the history pointer and reads across the wrap
    task automatic send_wrap_record();
        int produced;
        int span;
        int ref_dist;
        send_byte(LIT_MAX, 1'b0);
        for (int k = 0; k < LIT_MAX; k++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        produced = LIT_MAX;
        while (produced < HIST_DEPTH + 100) begin
            span = (produced < HIST_DEPTH - 1) ? produced : HIST_DEPTH - 1;
            if (produced > HIST_DEPTH)
                ref_dist = $urandom_range(1400, HIST_DEPTH - 1);
            else
                ref_dist = $urandom_range(1, span);
            send_backref(DIST_W'(ref_dist), '1, 1'b0);
            produced += MAX_RES;
        end
        send_byte(8'h2E, 1'b1);
    endtask

    initial begin
        int rec;
        int wrap_items;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.in_last <= 1'b0;
        rst_n         <= 1'b0;
        calm          = 1'b0;
        items_sent    = 0;
        wrap_items    = 0;
        cycle_count   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // pass-through extremes and both ends of the space-pair range
        send_byte(8'h00, 1'b0);
        send_byte(8'(LIT_MAX + 1), 1'b0);
        send_byte(8'(BREF_MIN - 1), 1'b0);
        send_byte(PAIR_MIN, 1'b0);
        send_byte(8'hFF, 1'b0);
        // shortest and longest literal runs, carrying code bytes through
        send_byte(LIT_MIN, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(LIT_MAX, 1'b0);
        send_byte(BREF_MIN, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(LIT_MIN, 1'b0);
        send_byte(LIT_MAX, 1'b0);
        send_byte(PAIR_MIN, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        // 16 bytes written: overlapping copy, zero distance, distance equal to
        // the bytes written, then one beyond them
        send_backref(DIST_W'(1), LEN_BITS'(0), 1'b0);
        send_backref(DIST_W'(0), '1, 1'b0);
        send_backref(DIST_W'(29), '1, 1'b0);
        send_backref(DIST_W'(40), LEN_BITS'(2), 1'b0);
        send_byte(8'h0A, 1'b1);
        // records cut off inside a literal run and inside a back-reference
        send_byte(8'(LIT_MIN + 2), 1'b1);
        send_byte(8'hA5, 1'b1);
        drain_results();

        // random records, one long wrapping record after a full drain
        rec = 0;
        while (items_sent - wrap_items < RANDOM_ITEMS + 27) begin
            calm = (rec % 5 == 3);
            if (rec == 4) begin
                drain_results();
                wrap_items = items_sent;
                send_wrap_record();
                wrap_items = items_sent - wrap_items;
            end else begin
                send_record($urandom_range(2, 18));
            end
            rec++;
        end
        calm = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_total == 0)
            $display("palmdoc_lz77_decompressor_tb OK");
        else
            $display("palmdoc_lz77_decompressor_tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pdlz_pkg.sv
rtl/pdlz_if.sv
rtl/pdlz_hist_ram.sv
rtl/pdlz_ctrl.sv
rtl/palmdoc_lz77_decompressor.sv
rtl/pdlz_checker.sv
tb/sv/palmdoc_lz77_decompressor_chk.sv
tb/sv/palmdoc_lz77_decompressor_tb.sv
